/* rtl/ea2bv_pkg.sv */
// Shared types, constants and the arctangent table for the orientation unit.
`default_nettype none
package ea2bv_pkg;
  localparam int unsigned CordicIterationsDefault = 14;
  localparam int unsigned AtanTableLen = 24;
  localparam int unsigned AngleW = 16;
  localparam int unsigned CompW = 16;
  localparam int unsigned CordW = 34;   // Q2.30 plus growth headroom
  localparam int unsigned SqW = 16;     // Q1.14 sine/cosine
  localparam int unsigned FifoDepth = 4;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [SqW-1:0] OneQ14 = 16'sd16384;
  localparam logic [35:0] PiQ30 = 36'd3373259426;
  localparam logic [14:0] UnitsPerTurn = 15'd23040;
  localparam logic [14:0] UnitsPerQuarter = 15'd5760;

  typedef struct packed {
    logic [AngleW-1:0] pitch;
    logic [AngleW-1:0] yaw;
    logic [AngleW-1:0] roll;
  } angles_t;

  // Folded angle: quadrant and CORDIC start angle.
  typedef struct packed {
    logic [1:0] q;
    logic signed [CordW-1:0] z;
  } fold_t;

  typedef struct packed {
    fold_t p;
    fold_t y;
    fold_t r;
  } folds_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CordW-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021685;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

/* rtl/euler_angles_to_basis_vectors_unit.sv */
// Top level: orientation angles to forward/right/up unit vectors.
// Order: fold, CORDIC, quadrant registers; queue; back product, sum and output registers.
// One item per cycle when not stalled; fully unrolled CORDIC and product pipelines set this.
// A 4-entry queue parts front and back so each side stalls on its own.
// Reset (rst_ni, async, active low) clears all valid flags and queue pointers.
`default_nettype none
module euler_angles_to_basis_vectors_unit #(
  parameter int unsigned CORDIC_ITERATIONS = ea2bv_pkg::CordicIterationsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic signed [15:0] pitch_deg_i,
  input  wire logic signed [15:0] yaw_deg_i,
  input  wire logic signed [15:0] roll_deg_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic signed [15:0] forward_x_o,
  output logic signed [15:0] forward_y_o,
  output logic signed [15:0] forward_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o
);
  import ea2bv_pkg::*;
  angles_t ang;
  logic fv, fs, qv, qs;
  logic signed [SqW-1:0] fsc [6];
  logic signed [SqW-1:0] qsc [6];
  logic signed [CompW-1:0] comp [9];

  assign ang.pitch = pitch_deg_i;
  assign ang.yaw = yaw_deg_i;
  assign ang.roll = roll_deg_i;

  ea2bv_front #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .angles_i(ang),
    .out_valid_o(fv), .out_stall_i(fs), .sc_o(fsc));

  ea2bv_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_stall_o(fs), .wr_data_i(fsc),
    .rd_valid_o(qv), .rd_stall_i(qs), .rd_data_o(qsc));

  ea2bv_back u_back (
    .clk_i, .rst_ni, .in_valid_i(qv), .in_stall_o(qs), .sc_i(qsc),
    .out_valid_o, .out_stall_i, .comp_o(comp));

  assign forward_x_o = comp[0];
  assign forward_y_o = comp[1];
  assign forward_z_o = comp[2];
  assign right_x_o = comp[3];
  assign right_y_o = comp[4];
  assign right_z_o = comp[5];
  assign up_x_o = comp[6];
  assign up_y_o = comp[7];
  assign up_z_o = comp[8];
endmodule
`default_nettype wire

/* rtl/ea2bv_fold.sv */
// Front stage: wraps each angle into one turn, splits quadrant, scales to radians.
`default_nettype none
module ea2bv_fold (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [ea2bv_pkg::AngleW-1:0] angle_i,
  output ea2bv_pkg::fold_t                fold_o
);
  import ea2bv_pkg::*;
  // Stage 1: wrap and quadrant. Stage 2: split multiply. Stage 3: reciprocal divide and sum.
  // pi in Q30 over 11520 splits into a whole part and a remainder; the remainder term is
  // divided by 256 with a shift and by 45 with a reciprocal multiply, exact for its range.
  localparam logic [18:0] RadPerUnitHi = 19'd292817;
  localparam logic [12:0] RadPerUnitLo = 13'd7586;
  localparam logic [18:0] Recip45 = 19'd372828;

  logic [14:0] t_q;
  logic [1:0]  q1_q, q2_q, q3_q;
  logic [30:0] hi_q;
  logic [25:0] lo_q;
  logic signed [CordW-1:0] z_q;
  logic signed [16:0] a;
  logic [15:0] r0;
  logic [14:0] r, t;
  logic [1:0] qd;
  logic [36:0] lo_prod;
  logic [12:0] lo_div;

  always_comb begin
    a = {angle_i[AngleW-1], angle_i};
    // a in [-32768,32767]: add turns until nonnegative, then reduce below one turn
    if (a < 0) begin
      if (a < -17'sd23040) r0 = 16'(a + 17'sd46080);
      else                 r0 = 16'(a + 17'sd23040);
    end else begin
      r0 = 16'(a);
    end
    if (r0 >= 16'(UnitsPerTurn)) r = 15'(r0 - 16'(UnitsPerTurn));
    else                         r = 15'(r0);
    if (r >= 15'd17280)      begin qd = 2'd3; t = r - 15'd17280; end
    else if (r >= 15'd11520) begin qd = 2'd2; t = r - 15'd11520; end
    else if (r >= UnitsPerQuarter) begin qd = 2'd1; t = r - UnitsPerQuarter; end
    else                     begin qd = 2'd0; t = r; end
  end

  assign lo_prod = 37'(lo_q[25:8]) * 37'(Recip45);
  assign lo_div = lo_prod[36:24];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t;
      q1_q <= qd;
      hi_q <= 31'(34'(t_q) * 34'(RadPerUnitHi));
      lo_q <= 26'(28'(t_q) * 28'(RadPerUnitLo)) + 26'd5760;
      q2_q <= q1_q;
      z_q <= CordW'(hi_q) + CordW'(lo_div);
      q3_q <= q2_q;
    end
  end

  assign fold_o.q = q3_q;
  assign fold_o.z = z_q;
endmodule
`default_nettype wire

/* rtl/ea2bv_cordic.sv */
// Unrolled CORDIC rotation pipeline giving quadrant-corrected Q1.14 sine and cosine.
`default_nettype none
module ea2bv_cordic #(
  parameter int unsigned CORDIC_ITERATIONS = ea2bv_pkg::CordicIterationsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  ea2bv_pkg::fold_t                   fold_i,
  output logic signed [ea2bv_pkg::SqW-1:0]   sin_o,
  output logic signed [ea2bv_pkg::SqW-1:0]   cos_o
);
  import ea2bv_pkg::*;
  localparam int unsigned N = (CORDIC_ITERATIONS < AtanTableLen) ?
                              CORDIC_ITERATIONS : AtanTableLen;

  logic signed [CordW-1:0] x_q [N+1];
  logic signed [CordW-1:0] y_q [N+1];
  logic signed [CordW-1:0] z_q [N+1];
  logic [1:0] qq [N+1];

  always_comb begin
    x_q[0] = CordicGain;
    y_q[0] = '0;
    z_q[0] = fold_i.z;
    qq[0]  = fold_i.q;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CordW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qq[i+1] <= qq[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q30(5'(i));
        end
      end
    end
  end

  function automatic logic signed [SqW-1:0] rnd(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] w;
    w = (v + 34'sd32768) >>> 16;
    if (w > 34'sd16384) return OneQ14;
    if (w < -34'sd16384) return -OneQ14;
    return SqW'(w);
  endfunction

  logic signed [SqW-1:0] s, c;
  always_comb begin
    s = rnd(y_q[N]);
    c = rnd(x_q[N]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (qq[N])
        2'd0: begin sin_o <= s;  cos_o <= c;  end
        2'd1: begin sin_o <= c;  cos_o <= -s; end
        2'd2: begin sin_o <= -s; cos_o <= -c; end
        default: begin sin_o <= -c; cos_o <= s; end
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/ea2bv_front.sv */
// Front part: angle folding and CORDIC for the three angles.
`default_nettype none
module ea2bv_front #(
  parameter int unsigned CORDIC_ITERATIONS = ea2bv_pkg::CordicIterationsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  ea2bv_pkg::angles_t        angles_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [ea2bv_pkg::SqW-1:0] sc_o [6]
);
  import ea2bv_pkg::*;
  localparam int unsigned N = (CORDIC_ITERATIONS < AtanTableLen) ?
                              CORDIC_ITERATIONS : AtanTableLen;
  localparam int unsigned Lat = 3 + N + 1;

  logic en;
  logic [Lat-1:0] vld_q;
  folds_t f;

  // Pipeline advances as a whole; it only halts when its last item can't leave.
  assign en = !(vld_q[Lat-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  ea2bv_fold u_fp (.clk_i, .en_i(en), .angle_i(angles_i.pitch), .fold_o(f.p));
  ea2bv_fold u_fy (.clk_i, .en_i(en), .angle_i(angles_i.yaw),   .fold_o(f.y));
  ea2bv_fold u_fr (.clk_i, .en_i(en), .angle_i(angles_i.roll),  .fold_o(f.r));

  ea2bv_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cp (
    .clk_i, .en_i(en), .fold_i(f.p), .sin_o(sc_o[0]), .cos_o(sc_o[1]));
  ea2bv_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cy (
    .clk_i, .en_i(en), .fold_i(f.y), .sin_o(sc_o[2]), .cos_o(sc_o[3]));
  ea2bv_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cr (
    .clk_i, .en_i(en), .fold_i(f.r), .sin_o(sc_o[4]), .cos_o(sc_o[5]));
endmodule
`default_nettype wire

/* rtl/ea2bv_queue.sv */
// Short queue of sine/cosine sets between front and back parts.
`default_nettype none
module ea2bv_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic      wr_stall_o,
  input  wire logic signed [ea2bv_pkg::SqW-1:0] wr_data_i [6],
  output logic      rd_valid_o,
  input  wire logic rd_stall_i,
  output logic signed [ea2bv_pkg::SqW-1:0] rd_data_o [6]
);
  import ea2bv_pkg::*;
  localparam int unsigned Aw = $clog2(FifoDepth);
  logic [6*SqW-1:0] mem_q [FifoDepth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0] cnt_q;
  logic wr, rd;
  logic [6*SqW-1:0] wpack;

  assign wr_stall_o = (cnt_q == (Aw+1)'(FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      wpack[k*SqW +: SqW] = wr_data_i[k];
      rd_data_o[k] = mem_q[rp_q][k*SqW +: SqW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wpack;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule
`default_nettype wire

/* rtl/ea2bv_back.sv */
// Back part: products, sums, rounding and the output register.
`default_nettype none
module ea2bv_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic signed [ea2bv_pkg::SqW-1:0] sc_i [6],
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic signed [ea2bv_pkg::CompW-1:0] comp_o [9]
);
  import ea2bv_pkg::*;
  // sc: 0 sp, 1 cp, 2 sy, 3 cy, 4 sr, 5 cr
  logic [2:0] vld_q;
  logic en;
  logic signed [31:0] p1_q [6];    // cp*cy cp*sy sp*cy sp*sy cr*sy cr*cy
  logic signed [31:0] p1b_q [4];   // sr*sy sr*cy sr*cp cr*cp
  logic signed [SqW-1:0] sp1_q, sr1_q, cr1_q;
  logic signed [48:0] v_q [9];
  logic signed [CompW-1:0] o_q [9];

  assign en = !(vld_q[2] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[2];
  assign comp_o = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[1:0], in_valid_i};
  end

  function automatic logic signed [CompW-1:0] fin(input logic signed [48:0] v);
    logic signed [48:0] w;
    w = (v + 49'sd134217728) >>> 28;
    if (w > 49'sd16384) return OneQ14;
    if (w < -49'sd16384) return -OneQ14;
    return CompW'(w);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[0] <= sc_i[1] * sc_i[3];
      p1_q[1] <= sc_i[1] * sc_i[2];
      p1_q[2] <= sc_i[0] * sc_i[3];
      p1_q[3] <= sc_i[0] * sc_i[2];
      p1_q[4] <= sc_i[5] * sc_i[2];
      p1_q[5] <= sc_i[5] * sc_i[3];
      p1b_q[0] <= sc_i[4] * sc_i[2];
      p1b_q[1] <= sc_i[4] * sc_i[3];
      p1b_q[2] <= sc_i[4] * sc_i[1];
      p1b_q[3] <= sc_i[5] * sc_i[1];
      sp1_q <= sc_i[0]; sr1_q <= sc_i[4]; cr1_q <= sc_i[5];
      // stage 2: second multiply and sum in Q2.42
      v_q[0] <= 49'(p1_q[0]) <<< 14;
      v_q[1] <= 49'(p1_q[1]) <<< 14;
      v_q[2] <= -(49'(sp1_q) <<< 28);
      v_q[3] <= -(49'(sr1_q) * 49'(p1_q[2])) + (49'(p1_q[4]) <<< 14);
      v_q[4] <= -(49'(sr1_q) * 49'(p1_q[3])) - (49'(p1_q[5]) <<< 14);
      v_q[5] <= -(49'(p1b_q[2]) <<< 14);
      v_q[6] <= (49'(cr1_q) * 49'(p1_q[2])) + (49'(p1b_q[0]) <<< 14);
      v_q[7] <= (49'(cr1_q) * 49'(p1_q[3])) - (49'(p1b_q[1]) <<< 14);
      v_q[8] <= 49'(p1b_q[3]) <<< 14;
      for (int k = 0; k < 9; k++) o_q[k] <= fin(v_q[k]);
    end
  end
endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the orientation to basis-vectors unit.
module testbench;
  localparam int unsigned NumRandom = 1900;
  localparam int unsigned IdleLimit = 5000;
  localparam logic signed [15:0] PosOne = 16'sd16384;
  localparam logic signed [15:0] NegOne = -16'sd16384;

  typedef struct {
    logic signed [15:0] v[9];
  } basis_t;

  typedef struct {
    logic signed [15:0] p, y, r;
    bit                 known;
    basis_t             res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] pitch_deg_i = '0, yaw_deg_i = '0, roll_deg_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;

  basis_t basis_q[$];
  int errors = 0;
  int idle_cycles = 0;
  stim_row_t rows[$];

  euler_angles_to_basis_vectors_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pitch_deg_i, .yaw_deg_i, .roll_deg_i,
    .out_valid_o, .out_stall_i,
    .forward_x_o(fx), .forward_y_o(fy), .forward_z_o(fz),
    .right_x_o(rx), .right_y_o(ry), .right_z_o(rz),
    .up_x_o(ux), .up_y_o(uy), .up_z_o(uz)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void angle_sin_cos(logic signed [15:0] a, output longint sn,
                                        output longint cs);
    longint atan_tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021685,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    longint r, q, t, x, y, z, dx, dy, s, c;
    r = longint'(a) % 23040;
    if (r < 0) r += 23040;
    q = r / 5760;
    t = r - q * 5760;
    z = (t * 64'sd3373259426 + 5760) / 11520;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 14; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = unit_clamp(floor_shift(x + 32768, 16));
    s = unit_clamp(floor_shift(y + 32768, 16));
    case (q)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic signed [15:0] round_q42(longint v);
    return 16'(unit_clamp(floor_shift(v + (64'sd1 << 27), 28)));
  endfunction

  function automatic basis_t orient_basis(logic signed [15:0] p, logic signed [15:0] y,
                                          logic signed [15:0] r);
    basis_t b;
    longint sp, cp, sy, cy, sr, cr, spcy, spsy;
    angle_sin_cos(p, sp, cp);
    angle_sin_cos(y, sy, cy);
    angle_sin_cos(r, sr, cr);
    spcy = sp * cy;
    spsy = sp * sy;
    b.v[0] = round_q42((cp * cy) * 16384);
    b.v[1] = round_q42((cp * sy) * 16384);
    b.v[2] = round_q42(-sp * 16384 * 16384);
    b.v[3] = round_q42(-sr * spcy + (cr * sy) * 16384);
    b.v[4] = round_q42(-sr * spsy - (cr * cy) * 16384);
    b.v[5] = round_q42((-sr * cp) * 16384);
    b.v[6] = round_q42(cr * spcy + (sr * sy) * 16384);
    b.v[7] = round_q42(cr * spsy - (sr * cy) * 16384);
    b.v[8] = round_q42((cr * cp) * 16384);
    return b;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_row(int p, int y, int r, bit known = 0,
                         int a0 = 0, int a1 = 0, int a2 = 0, int a3 = 0, int a4 = 0,
                         int a5 = 0, int a6 = 0, int a7 = 0, int a8 = 0);
    stim_row_t row;
    row.p = 16'(p); row.y = 16'(y); row.r = 16'(r);
    row.known = known;
    row.res.v = '{16'(a0), 16'(a1), 16'(a2), 16'(a3), 16'(a4), 16'(a5),
                  16'(a6), 16'(a7), 16'(a8)};
    rows.push_back(row);
  endtask

  // Accept and check results, and end the run if the bench sits idle too long.
  always @(posedge clk_i) begin
    basis_t want;
    logic signed [15:0] got[9];
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{fx, fy, fz, rx, ry, rz, ux, uy, uz};
        if (basis_q.size() == 0) report_mismatch("unexpected item", 0, 0);
        else begin
          want = basis_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want.v[k]) report_mismatch($sformatf("field %0d", k), got[k],
                                                      want.v[k]);
        end
      end
    end
  end

  // Receiver stall pattern.
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_item(logic signed [15:0] p, logic signed [15:0] y,
                           logic signed [15:0] r, bit known, basis_t res);
    in_valid_i <= 1'b1;
    pitch_deg_i <= p;
    yaw_deg_i <= y;
    roll_deg_i <= r;
    basis_q.push_back(known ? res : orient_basis(p, y, r));
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic maybe_gap(ref int burst);
    if (burst > 0) burst--;
    else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 4);
    end
  endtask

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 3) * 5760 + $urandom_range(0, 2) - 1);
      1: return $urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 15))
                                     : 16'sh8000 + 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    basis_t none;
    int burst;
    int limit;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Zero orientation: forward +x, right -y, up +z; the CORDIC residual leaves a
    // sine of one LSB, which shows up as +-1 in the small components.
    add_row(0, 0, 0, 1, 16384, 1, -1, 1, -16384, -1, 1, -1, 16384);
    // One full turn wraps to zero.
    add_row(23040, -23040, 23040, 1, 16384, 1, -1, 1, -16384, -1, 1, -1, 16384);
    add_row(32767, 32767, 32767);
    add_row(-32768, -32768, -32768);
    add_row(5760, 0, 0);
    add_row(11520, 5760, 17280);
    add_row(-5760, -11520, -17280);
    add_row(5759, 5761, 17279);
    add_row(1920, 2880, 3840);
    add_row(0, 5760, 11520);
    add_row(22, 23039, -1);
    add_row(-1, 1, 16'h5555);
    add_row(16'hAAAA, 16'h5555, 16'hAAAA);
    add_row(2880, 8640, 14400);
    burst = 4;
    foreach (rows[i]) begin
      send_item(rows[i].p, rows[i].y, rows[i].r, rows[i].known, rows[i].res);
      maybe_gap(burst);
    end
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        // Let the pipeline drain fully before resuming.
        in_valid_i <= 1'b0;
        while (basis_q.size() != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
      send_item(pick_angle(), pick_angle(), pick_angle(), 0, none);
      maybe_gap(burst);
    end
    in_valid_i <= 1'b0;
    limit = 0;
    while (basis_q.size() != 0 && limit < 20000) begin
      @(negedge clk_i);
      limit++;
    end
    repeat (40) @(negedge clk_i);
    if (errors == 0 && basis_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
